### design/sbfd_pkg.sv
`timescale 1ns / 1ps
// Package for the serial-bus frame decoder.
// Holds frame constants and the frame type passed from the collector to the unpacker.
// No dependencies.
package sbfd_pkg;

    // Frame framing bytes and geometry.
    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE   = 8'h00;
    localparam int FRAME_LEN  = 25;
    localparam int DATA_BYTES = 22;
    localparam int FS_BYTE    = 23;
    localparam int FS_BIT     = 3;
    localparam int NUM_CH     = 16;
    localparam int CH_W       = 11;
    localparam int POS_W      = $clog2(FRAME_LEN);
    localparam int IDX_W      = $clog2(NUM_CH);
    localparam int DATA_W     = DATA_BYTES * 8;

    // Position of the end byte within the frame.
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
    // Index of the final channel.
    localparam logic [IDX_W-1:0] LAST_CH  = IDX_W'(NUM_CH - 1);

    // One complete, checked frame: packed channel data and the failsafe flag.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              failsafe;
    } t_frame;

endpackage

### design/sbfd_collector.sv
`timescale 1ns / 1ps
// Byte collector for the serial-bus frame decoder: start-byte hunt and frame storage.
// Depends on sbfd_pkg.
module sbfd_collector (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rx_valid,
    output logic                 o_rx_ready,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_frame_valid,
    input  logic                 i_frame_ready,
    output sbfd_pkg::t_frame     o_frame
);
    import sbfd_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       r_frame [1:FS_BYTE];
    logic             w_accept;

    // The end byte can only be taken when the unpacker can take the frame.
    assign o_rx_ready = (r_pos != LAST_POS) || i_frame_ready;
    assign w_accept   = i_rx_valid && o_rx_ready;

    // A good frame is offered while its end byte is presented.
    assign o_frame_valid = i_rx_valid && (r_pos == LAST_POS) && (i_rx_byte == END_BYTE);

    // Next byte position: hunt for the start byte, then count through the frame.
    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            priority if (r_pos == '0) begin
                if (i_rx_byte == START_BYTE) begin
                    n_pos = POS_W'(1);
                end
            end else if (r_pos == LAST_POS) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // Store the data bytes and the flag byte; start and end bytes need no storage.
    always_ff @(posedge i_clk) begin
        if (w_accept && (r_pos != '0) && (r_pos != LAST_POS)) begin
            r_frame[r_pos] <= i_rx_byte;
        end
    end

    // Pack the data bytes least significant byte first.
    for (genvar g = 0; g < DATA_BYTES; g++) begin : g_pack
        assign o_frame.data[g*8 +: 8] = r_frame[g+1];
    end
    assign o_frame.failsafe = r_frame[FS_BYTE][FS_BIT];

endmodule

### design/sbfd_unpacker.sv
`timescale 1ns / 1ps
// Channel unpacker for the serial-bus frame decoder: frame snapshot and result register.
// Depends on sbfd_pkg.
module sbfd_unpacker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_frame_valid,
    output logic                    o_frame_ready,
    input  sbfd_pkg::t_frame        i_frame,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [sbfd_pkg::IDX_W-1:0] o_channel_index,
    output logic [sbfd_pkg::CH_W-1:0]  o_channel_value,
    output logic                    o_failsafe,
    output logic                    o_last
);
    import sbfd_pkg::*;

    t_frame           r_snap;
    logic             r_busy;
    logic [IDX_W-1:0] r_chan;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_idx;
    logic [CH_W-1:0]  r_val;
    logic             r_fs;
    logic             r_last;
    logic [CH_W-1:0]  w_chan [NUM_CH];
    logic             w_take;
    logic             w_load;

    assign o_frame_ready = !r_busy;
    assign w_take        = i_frame_valid && !r_busy;
    assign w_load        = r_busy && (!r_out_valid || i_ready);

    // Split the snapshot into its sixteen 11-bit channel fields.
    for (genvar g = 0; g < NUM_CH; g++) begin : g_chan
        assign w_chan[g] = r_snap.data[g*CH_W +: CH_W];
    end

    // Snapshot a good frame so the collector can start on the next one.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_snap <= i_frame;
        end
    end

    // Channel counter walks through the snapshot while busy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_chan <= '0;
        end else if (w_take) begin
            r_busy <= 1'b1;
            r_chan <= '0;
        end else if (w_load) begin
            r_chan <= r_chan + IDX_W'(1);
            if (r_chan == LAST_CH) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_idx  <= r_chan;
            r_val  <= w_chan[r_chan];
            r_fs   <= r_snap.failsafe;
            r_last <= (r_chan == LAST_CH);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_channel_index = r_idx;
    assign o_channel_value = r_val;
    assign o_failsafe      = r_fs;
    assign o_last          = r_last;

    // The last flag only ever rides on the final channel.
    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_channel_index == LAST_CH))
        else $error("last flag on a channel other than the final one");

    // Results of one frame follow each other without gaps in channel order.
    a_channel_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=>
        (o_valid && (o_channel_index == $past(o_channel_index) + IDX_W'(1))))
        else $error("channel sequence broken within a frame");

    // A taken frame starts unpacking at the first channel.
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_frame_valid && !r_busy) |=> (r_busy && (r_chan == '0)))
        else $error("frame taken but unpacking did not start at channel zero");

endmodule

### design/sbus_frame_decoder.sv
`timescale 1ns / 1ps
// Top level of the serial-bus 16-channel frame decoder.
// Depends on sbfd_pkg, sbfd_collector and sbfd_unpacker.
//
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+------------------------------------------------
//  rx in    | i_rx_valid / o_rx_ready | i_rx_byte
//  ch out   | o_ch_valid / i_ch_ready | o_channel_index, o_channel_value, o_failsafe,
//           |                         | o_last
//
// One byte is taken per cycle while i_rx_valid is high and o_rx_ready allows it.
// A good frame yields sixteen items from a frame snapshot, one per cycle unless i_ch_ready
// stalls; the end byte loads the snapshot and the busy flag, then the result register.
// The end byte of a frame waits only while the previous frame is still being unpacked.
// Reset (synchronous, active low) returns to hunting for the start byte.
// A stalled result register holds its item; input bytes up to the next end byte keep flowing.
module sbus_frame_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rx_valid,
    output logic                        o_rx_ready,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_ch_valid,
    input  logic                        i_ch_ready,
    output logic [sbfd_pkg::IDX_W-1:0]  o_channel_index,
    output logic [sbfd_pkg::CH_W-1:0]   o_channel_value,
    output logic                        o_failsafe,
    output logic                        o_last
);
    import sbfd_pkg::*;

    t_frame w_frame;
    logic   w_frame_valid;
    logic   w_frame_ready;

    // Start-byte hunt and frame storage.
    sbfd_collector u_collector (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_ready    (o_rx_ready),
        .i_rx_byte     (i_rx_byte),
        .o_frame_valid (w_frame_valid),
        .i_frame_ready (w_frame_ready),
        .o_frame       (w_frame)
    );

    // Channel unpacking into the result register.
    sbfd_unpacker u_unpacker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame_valid   (w_frame_valid),
        .o_frame_ready   (w_frame_ready),
        .i_frame         (w_frame),
        .o_valid         (o_ch_valid),
        .i_ready         (i_ch_ready),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_failsafe      (o_failsafe),
        .o_last          (o_last)
    );

endmodule
